### hdl/vhsc_pkg.sv
// Shared constants, types and helper functions for the VDI header check.
`default_nettype none

package vhsc_pkg;

  localparam int HEADER_BYTES = 512;
  localparam int CNT_W        = $clog2(HEADER_BYTES + 1);

  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int DISK_W     = 64;
  localparam int LIMIT_W    = 48;
  localparam int HDR_W      = 12;
  localparam int USED_W     = 30;
  localparam int PROD_W     = USED_W + WORD_W;
  localparam int SUM_W      = PROD_W + 1;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 48;

  localparam logic [WORD_W-1:0]  SIG_VALUE      = 32'hbeda107f;
  localparam logic [WORD_W-1:0]  VER_A          = 32'h00010001;
  localparam logic [WORD_W-1:0]  VER_B          = 32'h00010002;
  localparam logic [WORD_W-1:0]  MAX_HDR        = 32'd2048;
  localparam logic [WORD_W-1:0]  IMG_TYPE_DYN   = 32'd1;
  localparam logic [WORD_W-1:0]  IMG_TYPE_FIXED = 32'd2;
  localparam logic [LIMIT_W-1:0] MIN_END        = 48'd512;

  // Header field byte offsets
  localparam logic [CNT_W-1:0] SIG_OFS    = CNT_W'('h040);
  localparam logic [CNT_W-1:0] VER_OFS    = CNT_W'('h044);
  localparam logic [CNT_W-1:0] HDR_OFS    = CNT_W'('h048);
  localparam logic [CNT_W-1:0] TYPE_OFS   = CNT_W'('h04c);
  localparam logic [CNT_W-1:0] OFFSET_OFS = CNT_W'('h158);
  localparam logic [CNT_W-1:0] DISK_OFS   = CNT_W'('h170);
  localparam logic [CNT_W-1:0] BLK_OFS    = CNT_W'('h178);
  localparam logic [CNT_W-1:0] TOTAL_OFS  = CNT_W'('h180);
  localparam logic [CNT_W-1:0] ALLOC_OFS  = CNT_W'('h184);

  localparam int LONG_LEN    = 39;
  localparam int SHORT_LEN   = 34;
  localparam int MAGIC_IDX_W = $clog2(LONG_LEN);

  localparam logic [BYTE_W-1:0] LONG_MAGIC [LONG_LEN] = '{
    8'h3c, 8'h3c, 8'h3c, 8'h20,
    8'h4f, 8'h72, 8'h61, 8'h63, 8'h6c, 8'h65, 8'h20,
    8'h56, 8'h4d, 8'h20,
    8'h56, 8'h69, 8'h72, 8'h74, 8'h75, 8'h61, 8'h6c, 8'h42, 8'h6f, 8'h78, 8'h20,
    8'h44, 8'h69, 8'h73, 8'h6b, 8'h20,
    8'h49, 8'h6d, 8'h61, 8'h67, 8'h65, 8'h20,
    8'h3e, 8'h3e, 8'h3e
  };

  localparam logic [BYTE_W-1:0] SHORT_MAGIC [SHORT_LEN] = '{
    8'h3c, 8'h3c, 8'h3c, 8'h20,
    8'h51, 8'h45, 8'h4d, 8'h55, 8'h20,
    8'h56, 8'h4d, 8'h20,
    8'h56, 8'h69, 8'h72, 8'h74, 8'h75, 8'h61, 8'h6c, 8'h20,
    8'h44, 8'h69, 8'h73, 8'h6b, 8'h20,
    8'h49, 8'h6d, 8'h61, 8'h67, 8'h65, 8'h20,
    8'h3e, 8'h3e, 8'h3e
  };

  // Judge request from the capture stage to the arithmetic pipeline
  typedef struct packed {
    logic                pass;
    logic [HDR_W-1:0]    hdr;
    logic [WORD_W-1:0]   blk;
    logic [USED_W-1:0]   used;
    logic [WORD_W-1:0]   offset;
    logic [LIMIT_W-1:0]  limit;
  } req_t;

  function automatic logic [BYTE_W-1:0] long_magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (int'(idx) < LONG_LEN) begin
      b = LONG_MAGIC[idx];
    end
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] short_magic_byte(input logic [MAGIC_IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    if (int'(idx) < SHORT_LEN) begin
      b = SHORT_MAGIC[idx];
    end
    return b;
  endfunction

  function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  // Words are held in file order; prefer the little-endian reading unless it is zero
  function automatic logic [WORD_W-1:0] le_or_be(input logic [WORD_W-1:0] be);
    logic [WORD_W-1:0] le;
    le = swap32(be);
    return (le != '0) ? le : be;
  endfunction

endpackage

`default_nettype wire

### hdl/vhsc_capture.sv
// Input register, header field capture and header checks.
`default_nettype none

module vhsc_capture (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic [vhsc_pkg::BYTE_W-1:0]          in_byte_i,
  input  wire logic                                 in_last_i,
  input  wire logic [vhsc_pkg::LIMIT_W-1:0]         in_limit_i,
  output logic                                      req_valid_o,
  input  wire logic                                 req_ready_i,
  output vhsc_pkg::req_t                            req_o
);

  localparam int CW = vhsc_pkg::CNT_W;
  localparam int WW = vhsc_pkg::WORD_W;

  logic                              in_valid_q;
  logic [vhsc_pkg::BYTE_W-1:0]       in_byte_q;
  logic                              in_last_q;
  logic [vhsc_pkg::LIMIT_W-1:0]      in_limit_q;

  logic [CW-1:0]                     cnt_q, cnt_d;
  logic                              long_q, long_d;
  logic                              short_q, short_d;
  logic [WW-1:0]                     sig_q, sig_d;
  logic [WW-1:0]                     ver_q, ver_d;
  logic [WW-1:0]                     hdr_q, hdr_d;
  logic [WW-1:0]                     type_q, type_d;
  logic [WW-1:0]                     off_q, off_d;
  logic [vhsc_pkg::DISK_W-1:0]       disk_q, disk_d;
  logic [WW-1:0]                     blk_q, blk_d;
  logic [WW-1:0]                     total_q, total_d;
  logic [WW-1:0]                     alloc_q, alloc_d;

  logic                              a_valid_q;
  vhsc_pkg::req_t                    a_q, a_d;

  logic                              a_ready;
  logic                              in_fire;
  logic                              in_ready;
  logic                              close;

  assign a_ready  = !a_valid_q || req_ready_i;
  assign in_fire  = in_valid_q && (!in_last_q || a_ready);
  assign in_ready = !in_valid_q || in_fire;
  assign close    = in_fire && in_last_q;

  assign in_ready_o  = in_ready;
  assign req_valid_o = a_valid_q;
  assign req_o       = a_q;

  // Field capture for the byte at position cnt_q
  always_comb begin
    cnt_d   = cnt_q;
    long_d  = long_q;
    short_d = short_q;
    sig_d   = sig_q;
    ver_d   = ver_q;
    hdr_d   = hdr_q;
    type_d  = type_q;
    off_d   = off_q;
    disk_d  = disk_q;
    blk_d   = blk_q;
    total_d = total_q;
    alloc_d = alloc_q;
    if (in_fire && (cnt_q < CW'(vhsc_pkg::HEADER_BYTES))) begin
      cnt_d = cnt_q + CW'(1);
      if ((cnt_q < CW'(vhsc_pkg::LONG_LEN)) &&
          (in_byte_q != vhsc_pkg::long_magic_byte(cnt_q[vhsc_pkg::MAGIC_IDX_W-1:0]))) begin
        long_d = 1'b0;
      end
      if ((cnt_q < CW'(vhsc_pkg::SHORT_LEN)) &&
          (in_byte_q != vhsc_pkg::short_magic_byte(cnt_q[vhsc_pkg::MAGIC_IDX_W-1:0]))) begin
        short_d = 1'b0;
      end
      if (cnt_q[CW-1:2] == vhsc_pkg::SIG_OFS[CW-1:2]) begin
        sig_d = {sig_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::VER_OFS[CW-1:2]) begin
        ver_d = {ver_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::HDR_OFS[CW-1:2]) begin
        hdr_d = {hdr_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::TYPE_OFS[CW-1:2]) begin
        type_d = {type_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::OFFSET_OFS[CW-1:2]) begin
        off_d = {off_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:3] == vhsc_pkg::DISK_OFS[CW-1:3]) begin
        disk_d = {disk_q[vhsc_pkg::DISK_W-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::BLK_OFS[CW-1:2]) begin
        blk_d = {blk_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::TOTAL_OFS[CW-1:2]) begin
        total_d = {total_q[WW-9:0], in_byte_q};
      end else if (cnt_q[CW-1:2] == vhsc_pkg::ALLOC_OFS[CW-1:2]) begin
        alloc_d = {alloc_q[WW-9:0], in_byte_q};
      end
    end
  end

  // Header checks on the captured words, including the closing byte
  logic [WW-1:0] sig_le, ver_le, hdr_v, blk_v, type_le, type_v, used_v;
  logic          sig_ok, ver_ok, hdr_ok, used_ok;

  always_comb begin
    sig_le  = vhsc_pkg::swap32(sig_d);
    ver_le  = vhsc_pkg::swap32(ver_d);
    hdr_v   = vhsc_pkg::le_or_be(hdr_d);
    blk_v   = vhsc_pkg::le_or_be(blk_d);
    type_le = vhsc_pkg::swap32(type_d);
    type_v  = ((type_le == vhsc_pkg::IMG_TYPE_DYN) || (type_le == vhsc_pkg::IMG_TYPE_FIXED))
              ? type_le : type_d;
    used_v  = (type_v == vhsc_pkg::IMG_TYPE_FIXED) ? vhsc_pkg::le_or_be(total_d)
                                                   : vhsc_pkg::le_or_be(alloc_d);
    sig_ok  = (sig_le == vhsc_pkg::SIG_VALUE) || (sig_d == vhsc_pkg::SIG_VALUE);
    ver_ok  = (ver_le == vhsc_pkg::VER_A) || (ver_le == vhsc_pkg::VER_B) ||
              (ver_d == vhsc_pkg::VER_A) || (ver_d == vhsc_pkg::VER_B);
    hdr_ok  = (hdr_v != '0) && (hdr_v <= vhsc_pkg::MAX_HDR);
    used_ok = (used_v != '0) && (used_v[WW-1:vhsc_pkg::USED_W] == '0);

    a_d.pass   = (cnt_d == CW'(vhsc_pkg::HEADER_BYTES)) && (long_d || short_d) &&
                 sig_ok && ver_ok && hdr_ok && (disk_d != '0) && (blk_v != '0);
    a_d.hdr    = hdr_v[vhsc_pkg::HDR_W-1:0];
    a_d.blk    = blk_v;
    a_d.used   = used_ok ? used_v[vhsc_pkg::USED_W-1:0] : '0;
    a_d.offset = vhsc_pkg::le_or_be(off_d);
    a_d.limit  = in_limit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      in_byte_q  <= in_byte_i;
      in_last_q  <= in_last_i;
      in_limit_q <= in_limit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      long_q  <= 1'b1;
      short_q <= 1'b1;
      sig_q   <= '0;
      ver_q   <= '0;
      hdr_q   <= '0;
      type_q  <= '0;
      off_q   <= '0;
      disk_q  <= '0;
      blk_q   <= '0;
      total_q <= '0;
      alloc_q <= '0;
    end else if (close) begin
      cnt_q   <= '0;
      long_q  <= 1'b1;
      short_q <= 1'b1;
      sig_q   <= '0;
      ver_q   <= '0;
      hdr_q   <= '0;
      type_q  <= '0;
      off_q   <= '0;
      disk_q  <= '0;
      blk_q   <= '0;
      total_q <= '0;
      alloc_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      long_q  <= long_d;
      short_q <= short_d;
      sig_q   <= sig_d;
      ver_q   <= ver_d;
      hdr_q   <= hdr_d;
      type_q  <= type_d;
      off_q   <= off_d;
      disk_q  <= disk_d;
      blk_q   <= blk_d;
      total_q <= total_d;
      alloc_q <= alloc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (a_ready) begin
      a_valid_q <= close;
    end
  end

  always_ff @(posedge clk_i) begin
    if (close) begin
      a_q <= a_d;
    end
  end

endmodule

`default_nettype wire

### hdl/vhsc_judge.sv
// Image end arithmetic: multiply, add, clamp, and the result register.
`default_nettype none

module vhsc_judge (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 req_valid_i,
  output logic                                      req_ready_o,
  input  wire vhsc_pkg::req_t                       req_i,
  output logic                                      res_valid_o,
  input  wire logic                                 res_ready_i,
  output logic                                      res_accepted_o,
  output logic [vhsc_pkg::LIMIT_W-1:0]              res_end_o
);

  localparam int LW = vhsc_pkg::LIMIT_W;
  localparam int HW = vhsc_pkg::HDR_W;
  localparam int SW = vhsc_pkg::SUM_W;

  logic                             b_valid_q;
  logic                             b_pass_q;
  logic [HW-1:0]                    b_hdr_q;
  logic [vhsc_pkg::WORD_W-1:0]      b_off_q;
  logic [LW-1:0]                    b_lim_q;
  logic [vhsc_pkg::PROD_W-1:0]      b_prod_q;

  logic                             c_valid_q;
  logic                             c_pass_q;
  logic [SW-1:0]                    c_sum_q;
  logic [LW-1:0]                    c_lim_q;
  logic [HW-1:0]                    c_hcap_q;

  logic                             o_valid_q;
  logic                             o_acc_q;
  logic [LW-1:0]                    o_end_q, o_end_d;

  logic                             o_ready, c_ready, b_ready;
  logic [HW-1:0]                    hcap;
  logic [LW-1:0]                    e1, e3, e4;

  assign o_ready = !o_valid_q || res_ready_i;
  assign c_ready = !c_valid_q || o_ready;
  assign b_ready = !b_valid_q || c_ready;

  assign req_ready_o    = b_ready;
  assign res_valid_o    = o_valid_q;
  assign res_accepted_o = o_acc_q;
  assign res_end_o      = o_end_q;

  // Header size already clamped to the limit
  assign hcap = (LW'(b_hdr_q) > b_lim_q) ? b_lim_q[HW-1:0] : b_hdr_q;

  always_comb begin
    if ((c_sum_q == '0) || (c_sum_q > SW'(c_lim_q))) begin
      e1 = c_lim_q;
    end else begin
      e1 = c_sum_q[LW-1:0];
    end
    e3      = (e1 >= LW'(c_hcap_q)) ? e1 : LW'(c_hcap_q);
    e4      = (e3 < vhsc_pkg::MIN_END) ? vhsc_pkg::MIN_END : e3;
    o_end_d = c_pass_q ? e4 : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (b_ready) begin
        b_valid_q <= req_valid_i;
      end
      if (c_ready) begin
        c_valid_q <= b_valid_q;
      end
      if (o_ready) begin
        o_valid_q <= c_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && req_valid_i) begin
      b_pass_q <= req_i.pass;
      b_hdr_q  <= req_i.hdr;
      b_off_q  <= req_i.offset;
      b_lim_q  <= req_i.limit;
      b_prod_q <= vhsc_pkg::PROD_W'(req_i.used) * vhsc_pkg::PROD_W'(req_i.blk);
    end
    if (c_ready && b_valid_q) begin
      c_pass_q <= b_pass_q;
      c_sum_q  <= SW'(b_off_q) + SW'(b_prod_q);
      c_lim_q  <= b_lim_q;
      c_hcap_q <= hcap;
    end
    if (o_ready && c_valid_q) begin
      o_acc_q <= c_pass_q;
      o_end_q <= o_end_d;
    end
  end

endmodule

`default_nettype wire

### hdl/vdi_header_size_check.sv
// A closing request passes the input, capture request and judge b, c and o registers
// on its way to the master side. Throughput: one header byte per cycle; requests keep
// flowing while a result waits, until the capture request and judge registers are full.
// Per byte the capture stage is the only work; the 30x32 multiply sits in its own stage.
// Reset: rst_ni is asynchronous, active low; it empties the pipeline and clears
// the byte count and captured header words, and sets the magic match flags.
`default_nettype none

module vdi_header_size_check (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  output logic                                      s_axis_tready_o,
  // [7:0] data_byte, [55:8] extent_limit
  input  wire logic [vhsc_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  input  wire logic                                 s_axis_tlast_i,
  output logic                                      m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  // [47:0] file_end
  output logic [vhsc_pkg::OUT_DATA_W-1:0]           m_axis_tdata_o,
  // [0] accepted
  output logic                                      m_axis_tuser_o
);

  logic           req_valid;
  logic           req_ready;
  vhsc_pkg::req_t req;

  vhsc_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .in_byte_i   (s_axis_tdata_i[vhsc_pkg::BYTE_W-1:0]),
    .in_last_i   (s_axis_tlast_i),
    .in_limit_i  (s_axis_tdata_i[vhsc_pkg::BYTE_W +: vhsc_pkg::LIMIT_W]),
    .req_valid_o (req_valid),
    .req_ready_i (req_ready),
    .req_o       (req)
  );

  vhsc_judge u_judge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (req_valid),
    .req_ready_o    (req_ready),
    .req_i          (req),
    .res_valid_o    (m_axis_tvalid_o),
    .res_ready_i    (m_axis_tready_i),
    .res_accepted_o (m_axis_tuser_o),
    .res_end_o      (m_axis_tdata_o)
  );

endmodule

`default_nettype wire

### hdl/vhsc_checker.sv
// Port-level assertions for the VDI header check, bound to the top level.
`default_nettype none

module vhsc_checker (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 s_axis_tvalid_i,
  input  wire logic                                 s_axis_tready_o,
  input  wire logic                                 m_axis_tvalid_o,
  input  wire logic                                 m_axis_tready_i,
  input  wire logic [vhsc_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  input  wire logic                                 m_axis_tuser_o
);

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid_o)
    else $error("result valid during reset");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled result changed");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o == '0)
    else $error("rejected header with nonzero end");

  a_accept_min_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o >= vhsc_pkg::MIN_END)
    else $error("accepted header with end below 512");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("request side stalled while result side free");

endmodule

bind vdi_header_size_check vhsc_checker u_vhsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire

### dv/tb_top.sv
// Self-checking testbench for vdi_header_size_check: header byte streams against a predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int HDR_LEN     = 512;
  localparam int LONG_LEN    = 39;
  localparam int SHORT_LEN   = 34;
  localparam int OFS_SIG     = 'h040;
  localparam int OFS_VER     = 'h044;
  localparam int OFS_HDR     = 'h048;
  localparam int OFS_TYPE    = 'h04c;
  localparam int OFS_OFFSET  = 'h158;
  localparam int OFS_DISK    = 'h170;
  localparam int OFS_BLK     = 'h178;
  localparam int OFS_TOTAL   = 'h180;
  localparam int OFS_ALLOC   = 'h184;
  localparam int HOLD_CYCLES = 300;

  localparam logic [31:0] SIG_WORD   = 32'hbeda107f;
  localparam logic [31:0] VER_ONE    = 32'h00010001;
  localparam logic [31:0] VER_TWO    = 32'h00010002;
  localparam logic [31:0] HDR_MAX    = 32'd2048;
  localparam logic [31:0] TYPE_DYN   = 32'd1;
  localparam logic [31:0] TYPE_FIXED = 32'd2;
  localparam logic [31:0] USED_CAP   = 32'h4000_0000;
  localparam logic [47:0] END_FLOOR  = 48'd512;
  localparam logic [47:0] LIM_MAX    = 48'hFFFF_FFFF_FFFF;

  localparam logic [7:0] LONG_TEXT [LONG_LEN] = '{
    8'h3c, 8'h3c, 8'h3c, 8'h20,
    8'h4f, 8'h72, 8'h61, 8'h63, 8'h6c, 8'h65, 8'h20,
    8'h56, 8'h4d, 8'h20,
    8'h56, 8'h69, 8'h72, 8'h74, 8'h75, 8'h61, 8'h6c, 8'h42, 8'h6f, 8'h78, 8'h20,
    8'h44, 8'h69, 8'h73, 8'h6b, 8'h20,
    8'h49, 8'h6d, 8'h61, 8'h67, 8'h65, 8'h20,
    8'h3e, 8'h3e, 8'h3e
  };

  localparam logic [7:0] SHORT_TEXT [SHORT_LEN] = '{
    8'h3c, 8'h3c, 8'h3c, 8'h20,
    8'h51, 8'h45, 8'h4d, 8'h55, 8'h20,
    8'h56, 8'h4d, 8'h20,
    8'h56, 8'h69, 8'h72, 8'h74, 8'h75, 8'h61, 8'h6c, 8'h20,
    8'h44, 8'h69, 8'h73, 8'h6b, 8'h20,
    8'h49, 8'h6d, 8'h61, 8'h67, 8'h65, 8'h20,
    8'h3e, 8'h3e, 8'h3e
  };

  typedef enum logic [1:0] {MAG_LONG, MAG_SHORT, MAG_NONE} magic_e;

  typedef enum logic [4:0] {
    DC_BASE, DC_SHORT_BE, DC_NO_MAGIC, DC_BAD_SIG, DC_BAD_VER, DC_HDR_ZERO,
    DC_HDR_BIG, DC_HDR_MAX, DC_DISK_ZERO, DC_BLK_ZERO, DC_TYPE_FIXED,
    DC_USED_HUGE, DC_END_ZERO, DC_ALL_MAX, DC_HDR_WINS, DC_TYPE_ODD
  } dcase_e;

  // be_mask: [0] sig [1] ver [2] hdr [3] type [4] offset [5] blk [6] total [7] alloc
  typedef struct {
    magic_e      magic;
    int          bad_pos;
    logic [7:0]  bad_xor;
    logic [31:0] sig, ver, hdr, itype, offset, blk, total, alloc;
    logic [63:0] disk;
    logic [7:0]  be_mask;
    int          len;
    logic [47:0] limit;
    logic        pinned;
    logic        acc;
    logic [47:0] fend;
  } image_hdr_t;

  typedef struct packed {
    dcase_e      kind;
    logic [15:0] len;
    logic [47:0] limit;
    logic        pinned;
    logic        acc;
    logic [47:0] fend;
  } drow_t;

  typedef struct packed {
    logic        acc;
    logic [47:0] fend;
  } verdict_t;

  typedef struct packed {
    logic     pinned;
    verdict_t v;
  } pin_t;

  localparam int DIR_ROWS = 4;
  drow_t dir_rows [DIR_ROWS] = '{
    '{DC_BASE,       16'd1,   LIM_MAX,               1'b1, 1'b0, 48'd0},
    '{DC_BASE,       16'd40,  LIM_MAX,               1'b1, 1'b0, 48'd0},
    '{DC_BASE,       16'd512, 48'd0,                 1'b1, 1'b1, 48'd512},
    '{DC_ALL_MAX,    16'd512, LIM_MAX,               1'b0, 1'b0, 48'd0}
  };

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [vhsc_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                            s_axis_tlast_i  = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [vhsc_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tuser_o;

  vdi_header_size_check dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #12_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  int          idle_pct   = 0;
  int          stall_pct  = 0;
  int          mismatches = 0;
  int unsigned hold_left  = 0;
  logic [3:0]  hold_req   = '0;
  logic [3:0]  hold_seen  = '0;

  verdict_t verdict_q [$];
  pin_t     pin_q [$];

  // predicted header state
  logic [9:0]  hb_count = '0;
  logic        long_ok  = 1'b1;
  logic        short_ok = 1'b1;
  logic [31:0] sig_w = '0, ver_w = '0, hdr_w = '0, type_w = '0, off_w = '0;
  logic [31:0] blk_w = '0, total_w = '0, alloc_w = '0;
  logic [63:0] disk_w = '0;

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] pick_order(input logic [31:0] w);
    return (swap_bytes(w) != '0) ? swap_bytes(w) : w;
  endfunction

  function automatic logic [47:0] image_end(input logic [47:0] lim);
    logic [31:0] hdr, blk, used, itype, ver_le;
    logic [63:0] span;
    if (hb_count < HDR_LEN) return '0;
    if (!long_ok && !short_ok) return '0;
    if (swap_bytes(sig_w) != SIG_WORD && sig_w != SIG_WORD) return '0;
    ver_le = swap_bytes(ver_w);
    if (ver_le != VER_ONE && ver_le != VER_TWO && ver_w != VER_ONE && ver_w != VER_TWO)
      return '0;
    hdr = pick_order(hdr_w);
    if (hdr == '0 || hdr > HDR_MAX) return '0;
    if (disk_w == '0) return '0;
    blk = pick_order(blk_w);
    if (blk == '0) return '0;
    itype = swap_bytes(type_w);
    if (itype != TYPE_DYN && itype != TYPE_FIXED) itype = type_w;
    used = (itype == TYPE_FIXED) ? pick_order(total_w) : pick_order(alloc_w);
    span = {32'h0, pick_order(off_w)};
    if (used != '0 && used < USED_CAP) span = span + {32'h0, used} * {32'h0, blk};
    if (span == '0 || span > {16'h0, lim}) span = {16'h0, lim};
    if (span < {32'h0, hdr}) span = {32'h0, hdr};
    if (span > {16'h0, lim}) span = {16'h0, lim};
    if (span < {16'h0, END_FLOOR}) span = {16'h0, END_FLOOR};
    return span[47:0];
  endfunction

  task automatic track_byte(input logic [7:0] b, input logic closing, input logic [47:0] lim);
    int       pos;
    verdict_t v;
    pin_t     pin;
    pos = int'(hb_count);
    if (pos < HDR_LEN) begin
      if (pos < LONG_LEN && b != LONG_TEXT[pos]) long_ok = 1'b0;
      if (pos < SHORT_LEN && b != SHORT_TEXT[pos]) short_ok = 1'b0;
      if (pos >= OFS_SIG && pos < OFS_SIG + 4) sig_w = {sig_w[23:0], b};
      else if (pos >= OFS_VER && pos < OFS_VER + 4) ver_w = {ver_w[23:0], b};
      else if (pos >= OFS_HDR && pos < OFS_HDR + 4) hdr_w = {hdr_w[23:0], b};
      else if (pos >= OFS_TYPE && pos < OFS_TYPE + 4) type_w = {type_w[23:0], b};
      else if (pos >= OFS_OFFSET && pos < OFS_OFFSET + 4) off_w = {off_w[23:0], b};
      else if (pos >= OFS_DISK && pos < OFS_DISK + 8) disk_w = {disk_w[55:0], b};
      else if (pos >= OFS_BLK && pos < OFS_BLK + 4) blk_w = {blk_w[23:0], b};
      else if (pos >= OFS_TOTAL && pos < OFS_TOTAL + 4) total_w = {total_w[23:0], b};
      else if (pos >= OFS_ALLOC && pos < OFS_ALLOC + 4) alloc_w = {alloc_w[23:0], b};
      hb_count = hb_count + 10'd1;
    end
    if (closing) begin
      v.fend = image_end(lim);
      v.acc  = (v.fend != '0);
      if (pin_q.size() != 0) begin
        pin = pin_q.pop_front();
        if (pin.pinned) v = pin.v;
      end
      verdict_q = {verdict_q, v};
      hb_count = '0;
      long_ok  = 1'b1;
      short_ok = 1'b1;
      sig_w = '0; ver_w = '0; hdr_w = '0; type_w = '0; off_w = '0;
      blk_w = '0; total_w = '0; alloc_w = '0; disk_w = '0;
    end
  endtask

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  always @(posedge clk_i) begin
    verdict_t v;
    if (m_axis_tvalid_o && m_axis_tready_i) begin
      if (verdict_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected verdict acc=%0b end=%0h",
                                m_axis_tuser_o, m_axis_tdata_o));
      end else begin
        v = verdict_q.pop_front();
        if (m_axis_tuser_o !== v.acc)
          flag_mismatch($sformatf("accepted %0b, want %0b", m_axis_tuser_o, v.acc));
        if (m_axis_tdata_o !== v.fend)
          flag_mismatch($sformatf("file_end %0h, want %0h", m_axis_tdata_o, v.fend));
      end
    end
    if (s_axis_tvalid_i && s_axis_tready_o)
      track_byte(s_axis_tdata_i[7:0], s_axis_tlast_i, s_axis_tdata_i[55:8]);
  end

  // result side: random stalls plus a long hold-off each time hold_req changes
  always @(posedge clk_i) begin
    if (hold_seen != hold_req) begin
      hold_seen       <= hold_req;
      hold_left       <= HOLD_CYCLES;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left       <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic logic [47:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [7:0] word_byte(input logic [31:0] w, input int k, input logic be);
    return be ? w[8*(3-k) +: 8] : w[8*k +: 8];
  endfunction

  function automatic image_hdr_t good_image();
    image_hdr_t h;
    h.magic   = MAG_LONG;
    h.bad_pos = 0;
    h.bad_xor = 8'h01;
    h.sig     = SIG_WORD;
    h.ver     = VER_ONE;
    h.hdr     = 32'd400;
    h.itype   = TYPE_DYN;
    h.offset  = 32'h200;
    h.blk     = 32'h0010_0000;
    h.total   = 32'd64;
    h.alloc   = 32'd8;
    h.disk    = 64'h0000_0000_0400_0000;
    h.be_mask = '0;
    h.len     = HDR_LEN;
    h.limit   = LIM_MAX;
    h.pinned  = 1'b0;
    h.acc     = 1'b0;
    h.fend    = '0;
    return h;
  endfunction

  function automatic image_hdr_t directed_image(input drow_t r);
    image_hdr_t h;
    h = good_image();
    case (r.kind)
      DC_SHORT_BE: begin
        h.magic   = MAG_SHORT;
        h.be_mask = 8'hFF;
        h.ver     = VER_TWO;
      end
      DC_NO_MAGIC: begin
        h.magic   = MAG_NONE;
        h.bad_pos = 20;
        h.bad_xor = 8'h20;
      end
      DC_BAD_SIG:    h.sig = 32'hbeda1080;
      DC_BAD_VER:    h.ver = 32'h00010003;
      DC_HDR_ZERO:   h.hdr = 32'd0;
      DC_HDR_BIG:    h.hdr = 32'd2049;
      DC_HDR_MAX:    h.hdr = HDR_MAX;
      DC_DISK_ZERO:  h.disk = '0;
      DC_BLK_ZERO:   h.blk = '0;
      DC_TYPE_FIXED: begin
        h.itype = TYPE_FIXED;
        h.total = 32'd100;
        h.alloc = 32'd3;
      end
      DC_USED_HUGE:  h.alloc = USED_CAP;
      DC_END_ZERO: begin
        h.offset = '0;
        h.alloc  = '0;
      end
      DC_ALL_MAX: begin
        h.offset = 32'hFFFF_FFFF;
        h.alloc  = USED_CAP - 32'd1;
        h.blk    = 32'hFFFF_FFFF;
        h.disk   = '1;
        h.hdr    = HDR_MAX;
      end
      DC_HDR_WINS: begin
        h.offset = 32'd16;
        h.alloc  = '0;
        h.hdr    = HDR_MAX;
      end
      DC_TYPE_ODD: begin
        h.itype   = 32'd7;
        h.be_mask = 8'h08;
      end
      default: ;
    endcase
    h.len    = int'(r.len);
    h.limit  = r.limit;
    h.pinned = r.pinned;
    h.acc    = r.acc;
    h.fend   = r.fend;
    return h;
  endfunction

  function automatic logic [31:0] rand_count();
    case ($urandom_range(5))
      0:       return '0;
      1:       return $urandom;
      2:       return $urandom_range(32'h3FFF_FFFE, 32'h4000_0001);
      default: return $urandom_range(1, 4096);
    endcase
  endfunction

  function automatic image_hdr_t rand_image();
    image_hdr_t h;
    h = good_image();
    h.magic   = $urandom_range(1) ? MAG_LONG : MAG_SHORT;
    h.be_mask = 8'($urandom);
    h.ver     = $urandom_range(1) ? VER_ONE : VER_TWO;
    case ($urandom_range(9))
      0:       h.hdr = 32'd1;
      1:       h.hdr = HDR_MAX;
      default: h.hdr = $urandom_range(1, 2048);
    endcase
    case ($urandom_range(3))
      0:       h.itype = TYPE_DYN;
      1:       h.itype = TYPE_FIXED;
      2:       h.itype = $urandom;
      default: h.itype = $urandom_range(0, 3);
    endcase
    case ($urandom_range(3))
      0:       h.offset = '0;
      1:       h.offset = $urandom;
      default: h.offset = $urandom_range(0, 32'h0010_0000);
    endcase
    case ($urandom_range(2))
      0:       h.blk = $urandom;
      1:       h.blk = 32'h1 << $urandom_range(9, 24);
      default: h.blk = $urandom_range(1, 4096);
    endcase
    h.total = rand_count();
    h.alloc = rand_count();
    h.disk  = {32'($urandom), 32'($urandom)};
    h.len   = int'($urandom_range(1, 48));
    case ($urandom_range(5))
      0:       h.limit = '0;
      1:       h.limit = rand48();
      2:       h.limit = LIM_MAX;
      3:       h.limit = 48'($urandom_range(0, 4096));
      default: h.limit = {8'h0, 8'($urandom), 32'($urandom)};
    endcase
    // a quarter of the headers carry one defect
    if ($urandom_range(3) == 0) begin
      case ($urandom_range(7))
        0: begin
          h.magic   = MAG_NONE;
          h.bad_pos = $urandom_range(0, SHORT_LEN - 1);
          h.bad_xor = 8'($urandom_range(1, 255));
        end
        1:       h.sig  = $urandom;
        2:       h.ver  = $urandom;
        3:       h.hdr  = $urandom;
        4:       h.disk = '0;
        5:       h.blk  = '0;
        6:       h.len  = 1;
        default: h.len  = int'($urandom_range(1, LONG_LEN));
      endcase
    end
    return h;
  endfunction

  task automatic offer_byte(input logic [7:0] b, input logic closing, input logic [47:0] lim);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {lim, b};
    s_axis_tlast_i  <= closing;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  task automatic send_image(input image_hdr_t h);
    logic [7:0] b;
    logic       closing;
    pin_t       pin;
    pin.pinned = h.pinned;
    pin.v.acc  = h.acc;
    pin.v.fend = h.fend;
    pin_q = {pin_q, pin};
    for (int p = 0; p < h.len; p++) begin
      b = 8'($urandom);
      if (p < LONG_LEN && h.magic != MAG_SHORT) b = LONG_TEXT[p];
      if (p < SHORT_LEN && h.magic == MAG_SHORT) b = SHORT_TEXT[p];
      if (h.magic == MAG_NONE && p == h.bad_pos) b = b ^ h.bad_xor;
      if (p >= OFS_SIG && p < OFS_SIG + 4)
        b = word_byte(h.sig, p - OFS_SIG, h.be_mask[0]);
      else if (p >= OFS_VER && p < OFS_VER + 4)
        b = word_byte(h.ver, p - OFS_VER, h.be_mask[1]);
      else if (p >= OFS_HDR && p < OFS_HDR + 4)
        b = word_byte(h.hdr, p - OFS_HDR, h.be_mask[2]);
      else if (p >= OFS_TYPE && p < OFS_TYPE + 4)
        b = word_byte(h.itype, p - OFS_TYPE, h.be_mask[3]);
      else if (p >= OFS_OFFSET && p < OFS_OFFSET + 4)
        b = word_byte(h.offset, p - OFS_OFFSET, h.be_mask[4]);
      else if (p >= OFS_DISK && p < OFS_DISK + 8)
        b = h.disk[8*(p-OFS_DISK) +: 8];
      else if (p >= OFS_BLK && p < OFS_BLK + 4)
        b = word_byte(h.blk, p - OFS_BLK, h.be_mask[5]);
      else if (p >= OFS_TOTAL && p < OFS_TOTAL + 4)
        b = word_byte(h.total, p - OFS_TOTAL, h.be_mask[6]);
      else if (p >= OFS_ALLOC && p < OFS_ALLOC + 4)
        b = word_byte(h.alloc, p - OFS_ALLOC, h.be_mask[7]);
      closing = (p == h.len - 1);
      offer_byte(b, closing, closing ? h.limit : rand48());
    end
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (verdict_q.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    static int  idle_mix  [4] = '{0, 47, 0, 27};
    static int  stall_mix [4] = '{0, 0, 47, 27};
    image_hdr_t h;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) send_image(directed_image(dir_rows[i]));
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_mix[ph];
      stall_pct = stall_mix[ph];
      repeat (8) send_image(rand_image());
      drain();
    end

    // result side held off while short requests keep coming: input must back up
    idle_pct  = 0;
    stall_pct = 0;
    hold_req <= hold_req + 4'd1;
    repeat (30) begin
      h = good_image();
      h.len   = $urandom_range(1, 4);
      h.limit = rand48();
      send_image(h);
    end
    drain();

    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
